[design/vca_pkg.sv]
package vca_pkg;

  // Default voice storage and the voice count that reset selects.
  localparam int VOICES_DEF = 8;
  localparam int COUNT_RST  = 8;

  // Fixed field widths of the event, result and configuration beats.
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int VOICE_W  = 3;
  localparam int POLICY_W = 2;
  localparam int CFG_W    = 4;

  // Event kinds.
  typedef enum logic {
    OP_NOTE_ON  = 1'b0,
    OP_NOTE_OFF = 1'b1
  } op_e;

  // Stealing policies; the unused code behaves as no stealing.
  typedef enum logic [POLICY_W-1:0] {
    POL_NONE   = 2'd0,
    POL_OLDEST = 2'd1,
    POL_LOWEST = 2'd2
  } policy_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_STEAL_POLICY = 1'b0,
    CFG_VOICE_COUNT  = 1'b1
  } cfg_idx_e;

  // Control of the shared scan compare unit.
  typedef struct packed {
    logic start;
    logic step;
    logic mode_lt;
  } scan_ctl_t;

  // Commands to the voice list storage.
  typedef struct packed {
    logic rebuild;
    logic note_on;
    logic note_off;
    logic act_hit;
    logic free_hit;
  } list_cmd_t;

endpackage

[design/vca_scan.sv]
module vca_scan #(
  parameter int  VOICES = vca_pkg::VOICES_DEF,
  localparam int IW     = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int CW     = $clog2(VOICES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vca_pkg::scan_ctl_t          ctl_i,
  input  logic [vca_pkg::NOTE_W-1:0]  ref_i,
  input  logic [CW-1:0]               limit_i,
  input  logic [vca_pkg::NOTE_W-1:0]  cand_i,
  input  logic                        cand_ok_i,
  output logic [IW-1:0]               idx_o,
  output logic                        match_o,
  output logic                        done_o
);

  logic [IW-1:0]              idx_q;
  logic [vca_pkg::NOTE_W-1:0] ref_q;

  // One comparator serves both the lowest-note search and the equality search.
  assign match_o = cand_ok_i && (ctl_i.mode_lt ? (cand_i < ref_q) : (cand_i == ref_q));

  // The scan ends at the last position, or at the first hit of an equality search.
  assign done_o = (CW'(idx_q) + CW'(1) == limit_i) || (!ctl_i.mode_lt && match_o);

  assign idx_o = idx_q;

  // Position counter and running reference.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ref_q <= '0;
    end else if (ctl_i.start) begin
      idx_q <= '0;
      ref_q <= ref_i;
    end else if (ctl_i.step) begin
      idx_q <= idx_q + IW'(1);
      if (ctl_i.mode_lt && match_o) begin
        ref_q <= cand_i;
      end
    end
  end

endmodule

[design/vca_lists.sv]
module vca_lists #(
  parameter int  VOICES = vca_pkg::VOICES_DEF,
  localparam int IW     = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int CW     = $clog2(VOICES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vca_pkg::list_cmd_t          cmd_i,
  input  logic [CW-1:0]               count_i,
  input  logic [IW-1:0]               voice_i,
  input  logic [IW-1:0]               pos_i,
  input  logic [vca_pkg::NOTE_W-1:0]  note_i,
  input  logic [IW-1:0]               rd_pos_i,
  input  logic [IW-1:0]               rd_voice_i,
  output logic [IW-1:0]               free_front_o,
  output logic [IW-1:0]               act_front_o,
  output logic [IW-1:0]               act_rd_o,
  output logic [vca_pkg::NOTE_W-1:0]  note_rd_o,
  output logic                        play_rd_o,
  output logic [CW-1:0]               free_count_o,
  output logic [CW-1:0]               act_count_o
);

  localparam int CountRst = (vca_pkg::COUNT_RST <= VOICES) ? vca_pkg::COUNT_RST : VOICES;

  logic [IW-1:0]              act_q  [VOICES];
  logic [IW-1:0]              act_d  [VOICES];
  logic [IW-1:0]              act_nx [VOICES];
  logic [IW-1:0]              free_q [VOICES];
  logic [IW-1:0]              free_d [VOICES];
  logic [IW-1:0]              free_nx[VOICES];
  logic [vca_pkg::NOTE_W-1:0] note_q [VOICES];
  logic [vca_pkg::NOTE_W-1:0] note_d [VOICES];
  logic [VOICES-1:0]          play_q;
  logic [VOICES-1:0]          play_d;
  logic [CW-1:0]              act_count_q;
  logic [CW-1:0]              act_count_d;
  logic [CW-1:0]              free_count_q;
  logic [CW-1:0]              free_count_d;

  // Read ports.
  assign free_front_o = free_q[0];
  assign act_front_o  = act_q[0];
  assign act_rd_o     = act_q[rd_pos_i];
  assign note_rd_o    = note_q[rd_voice_i];
  assign play_rd_o    = play_q[rd_voice_i];
  assign free_count_o = free_count_q;
  assign act_count_o  = act_count_q;

  // Per-entry next values; removal shifts the tail of a list one place forward.
  for (genvar g = 0; g < VOICES; g++) begin : g_entry
    if (g < VOICES - 1) begin : g_shift
      assign act_nx[g]  = act_q[g+1];
      assign free_nx[g] = free_q[g+1];
    end else begin : g_last
      assign act_nx[g]  = act_q[g];
      assign free_nx[g] = free_q[g];
    end

    always_comb begin
      act_d[g]  = act_q[g];
      free_d[g] = free_q[g];
      note_d[g] = note_q[g];
      play_d[g] = play_q[g];
      if (cmd_i.rebuild) begin
        free_d[g] = IW'(g);
        note_d[g] = '0;
        play_d[g] = 1'b0;
      end else if (cmd_i.note_on) begin
        // The voice moves to the back of the active list, or is appended.
        if (cmd_i.act_hit) begin
          if (CW'(g + 1) == act_count_q) begin
            act_d[g] = voice_i;
          end else if (IW'(g) >= pos_i) begin
            act_d[g] = act_nx[g];
          end
        end else if (CW'(g) == act_count_q) begin
          act_d[g] = voice_i;
        end
        if (cmd_i.free_hit) begin
          free_d[g] = free_nx[g];
        end
        if (voice_i == IW'(g)) begin
          note_d[g] = note_i;
          play_d[g] = 1'b1;
        end
      end else if (cmd_i.note_off) begin
        // The voice leaves the active list and goes to the back of the free list.
        if (IW'(g) >= pos_i) begin
          act_d[g] = act_nx[g];
        end
        if (CW'(g) == free_count_q) begin
          free_d[g] = voice_i;
        end
        if (voice_i == IW'(g)) begin
          play_d[g] = 1'b0;
        end
      end
    end
  end

  // List lengths.
  always_comb begin
    act_count_d  = act_count_q;
    free_count_d = free_count_q;
    if (cmd_i.rebuild) begin
      act_count_d  = '0;
      free_count_d = count_i;
    end else if (cmd_i.note_on) begin
      if (!cmd_i.act_hit && act_count_q != CW'(VOICES)) begin
        act_count_d = act_count_q + CW'(1);
      end
      if (cmd_i.free_hit) begin
        free_count_d = free_count_q - CW'(1);
      end
    end else if (cmd_i.note_off) begin
      act_count_d = act_count_q - CW'(1);
      if (free_count_q != CW'(VOICES)) begin
        free_count_d = free_count_q + CW'(1);
      end
    end
  end

  // The active order has no defined contents until written.
  always_ff @(posedge clk_i) begin
    act_q <= act_d;
  end

  // Free order, notes, playing flags and counts come up as after a rebuild.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        free_q[i] <= IW'(i);
        note_q[i] <= '0;
      end
      play_q       <= '0;
      act_count_q  <= '0;
      free_count_q <= CW'(CountRst);
    end else begin
      free_q       <= free_d;
      note_q       <= note_d;
      play_q       <= play_d;
      act_count_q  <= act_count_d;
      free_count_q <= free_count_d;
    end
  end

endmodule

[design/poly_voice_allocator.sv]
// Channel   Direction  Handshake                   Payload
// event     in         in_valid_i / in_stall_o     operation_i, note_i, velocity_i
// result    out        out_valid_o / out_stall_i   found_o, voice_o, gate_o, note_out_o,
//                                                  velocity_out_o, stolen_o
// config    in         cfg_we_i                    cfg_idx_i, cfg_data_i
//
// An event that uses a free voice or the oldest active voice goes from acceptance through
// the decide, apply and done steps to its result beat. A note-off scans the active list
// one position a cycle. A lowest-note steal scans the voices and then the active list
// through the same comparator. After reset all voices are free in ascending order and
// the block is ready at once. A waiting result beat holds the sequencer until the output
// side takes it.
module poly_voice_allocator #(
  parameter int  VOICES = vca_pkg::VOICES_DEF,
  localparam int IW     = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int CW     = $clog2(VOICES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [vca_pkg::NOTE_W-1:0]   note_i,
  input  logic [vca_pkg::VEL_W-1:0]    velocity_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [vca_pkg::VOICE_W-1:0]  voice_o,
  output logic                         gate_o,
  output logic [vca_pkg::NOTE_W-1:0]   note_out_o,
  output logic [vca_pkg::VEL_W-1:0]    velocity_out_o,
  output logic                         stolen_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [vca_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int CountRst = (vca_pkg::COUNT_RST <= VOICES) ? vca_pkg::COUNT_RST : VOICES;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_EVAL,
    S_APPLY,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_OFF,
    PH_LOW,
    PH_POS
  } phase_e;

  state_e                          state_q;
  phase_e                          phase_q;
  vca_pkg::op_e                    op_q;
  logic [vca_pkg::NOTE_W-1:0]      note_q;
  logic [vca_pkg::VEL_W-1:0]       vel_q;
  logic [IW-1:0]                   pick_q;
  logic [IW-1:0]                   pos_q;
  logic                            hit_q;
  logic                            act_hit_q;
  logic                            free_hit_q;
  logic                            found_q;
  logic                            stolen_q;
  logic                            out_valid_q;
  logic                            out_found_q;
  logic [vca_pkg::VOICE_W-1:0]     out_voice_q;
  logic                            out_gate_q;
  logic [vca_pkg::NOTE_W-1:0]      out_note_q;
  logic [vca_pkg::VEL_W-1:0]       out_vel_q;
  logic                            out_stolen_q;
  logic [vca_pkg::POLICY_W-1:0]    policy_q;
  logic [CW-1:0]                   voice_count_q;
  logic [CW-1:0]                   count_clamp;

  vca_pkg::scan_ctl_t              scan_ctl;
  vca_pkg::list_cmd_t              list_cmd;
  logic [vca_pkg::NOTE_W-1:0]      scan_ref;
  logic [CW-1:0]                   scan_limit;
  logic [vca_pkg::NOTE_W-1:0]      cand_key;
  logic                            cand_ok;
  logic [IW-1:0]                   cand_voice;
  logic [IW-1:0]                   scan_idx;
  logic                            scan_match;
  logic                            scan_done;
  logic [IW-1:0]                   rd_voice;
  logic [IW-1:0]                   free_front;
  logic [IW-1:0]                   act_front;
  logic [IW-1:0]                   act_rd;
  logic [vca_pkg::NOTE_W-1:0]      note_rd;
  logic                            play_rd;
  logic [CW-1:0]                   free_count;
  logic [CW-1:0]                   act_count;
  logic                            off_scan;
  logic                            low_scan;
  logic                            pos_scan;

  // Handshake and result beat.
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign voice_o        = out_voice_q;
  assign gate_o         = out_gate_q;
  assign note_out_o     = out_note_q;
  assign velocity_out_o = out_vel_q;
  assign stolen_o       = out_stolen_q;

  // A voice count write is clamped into one to the number of voices.
  always_comb begin
    if (cfg_data_i == '0) begin
      count_clamp = CW'(1);
    end else if (int'(cfg_data_i) > VOICES) begin
      count_clamp = CW'(VOICES);
    end else begin
      count_clamp = CW'(cfg_data_i);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q      <= vca_pkg::POL_NONE;
      voice_count_q <= CW'(CountRst);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == vca_pkg::CFG_STEAL_POLICY) begin
        policy_q <= cfg_data_i[vca_pkg::POLICY_W-1:0];
      end else begin
        voice_count_q <= count_clamp;
      end
    end
  end

  // Scans that start from the decision step or after a lowest-note search.
  assign off_scan = (op_q == vca_pkg::OP_NOTE_OFF) && (act_count != '0);
  assign low_scan = (op_q == vca_pkg::OP_NOTE_ON) && (free_count == '0) &&
                    (policy_q == vca_pkg::POL_LOWEST);
  assign pos_scan = (phase_q == PH_LOW) && hit_q && (act_count != '0);

  // Scan operands: voices by index for the lowest note, otherwise the active list.
  always_comb begin
    scan_ctl.start   = ((state_q == S_DECIDE) && (off_scan || low_scan)) ||
                       ((state_q == S_EVAL) && pos_scan);
    scan_ctl.step    = (state_q == S_SCAN);
    scan_ctl.mode_lt = (phase_q == PH_LOW);
    scan_ref         = (state_q == S_EVAL) ? vca_pkg::NOTE_W'(pick_q) : note_q;
    scan_limit       = (phase_q == PH_LOW) ? voice_count_q : act_count;
    cand_voice       = (phase_q == PH_LOW) ? scan_idx : act_rd;
    cand_key         = (phase_q == PH_POS) ? vca_pkg::NOTE_W'(act_rd) : note_rd;
    cand_ok          = (phase_q == PH_OFF) ? play_rd : 1'b1;
    rd_voice         = (state_q == S_APPLY) ? pick_q : cand_voice;
  end

  // List updates: a rebuild on a voice count write, the event's move when applied.
  always_comb begin
    list_cmd.rebuild  = cfg_we_i && (cfg_idx_i == vca_pkg::CFG_VOICE_COUNT);
    list_cmd.note_on  = (state_q == S_APPLY) && (op_q == vca_pkg::OP_NOTE_ON);
    list_cmd.note_off = (state_q == S_APPLY) && (op_q == vca_pkg::OP_NOTE_OFF);
    list_cmd.act_hit  = act_hit_q;
    list_cmd.free_hit = free_hit_q;
  end

  vca_scan #(
    .VOICES(VOICES)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (scan_ctl),
    .ref_i    (scan_ref),
    .limit_i  (scan_limit),
    .cand_i   (cand_key),
    .cand_ok_i(cand_ok),
    .idx_o    (scan_idx),
    .match_o  (scan_match),
    .done_o   (scan_done)
  );

  vca_lists #(
    .VOICES(VOICES)
  ) u_lists (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (list_cmd),
    .count_i     (count_clamp),
    .voice_i     (pick_q),
    .pos_i       (pos_q),
    .note_i      (note_q),
    .rd_pos_i    (scan_idx),
    .rd_voice_i  (rd_voice),
    .free_front_o(free_front),
    .act_front_o (act_front),
    .act_rd_o    (act_rd),
    .note_rd_o   (note_rd),
    .play_rd_o   (play_rd),
    .free_count_o(free_count),
    .act_count_o (act_count)
  );

  // Sequencer with the event registers and the result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_OFF;
      op_q         <= vca_pkg::OP_NOTE_ON;
      note_q       <= '0;
      vel_q        <= '0;
      pick_q       <= '0;
      pos_q        <= '0;
      hit_q        <= 1'b0;
      act_hit_q    <= 1'b0;
      free_hit_q   <= 1'b0;
      found_q      <= 1'b0;
      stolen_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_voice_q  <= '0;
      out_gate_q   <= 1'b0;
      out_note_q   <= '0;
      out_vel_q    <= '0;
      out_stolen_q <= 1'b0;
    end else begin
      // A taken beat clears the valid unless the done step loads a new one.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= vca_pkg::op_e'(operation_i);
            note_q  <= note_i;
            vel_q   <= velocity_i;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          hit_q      <= 1'b0;
          act_hit_q  <= 1'b0;
          free_hit_q <= 1'b0;
          found_q    <= 1'b0;
          stolen_q   <= 1'b0;
          if (op_q == vca_pkg::OP_NOTE_OFF) begin
            phase_q <= PH_OFF;
            state_q <= off_scan ? S_SCAN : S_DONE;
          end else if (free_count != '0) begin
            pick_q     <= free_front;
            free_hit_q <= 1'b1;
            state_q    <= S_APPLY;
          end else begin
            case (policy_q)
              vca_pkg::POL_OLDEST: begin
                if (act_count != '0) begin
                  pick_q    <= act_front;
                  pos_q     <= '0;
                  act_hit_q <= 1'b1;
                  state_q   <= S_APPLY;
                end else begin
                  state_q <= S_DONE;
                end
              end
              vca_pkg::POL_LOWEST: begin
                phase_q <= PH_LOW;
                state_q <= S_SCAN;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_match) begin
            pick_q <= cand_voice;
            pos_q  <= scan_idx;
            hit_q  <= 1'b1;
          end
          if (scan_done) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (phase_q)
            PH_OFF: begin
              state_q <= hit_q ? S_APPLY : S_DONE;
            end
            PH_LOW: begin
              // Find where the chosen voice sits in the active list.
              if (pos_scan) begin
                hit_q   <= 1'b0;
                phase_q <= PH_POS;
                state_q <= S_SCAN;
              end else begin
                state_q <= hit_q ? S_APPLY : S_DONE;
              end
            end
            PH_POS: begin
              act_hit_q <= hit_q;
              state_q   <= S_APPLY;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_APPLY: begin
          found_q  <= 1'b1;
          stolen_q <= (op_q == vca_pkg::OP_NOTE_ON) && play_rd;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_found_q  <= found_q;
            out_voice_q  <= found_q ? vca_pkg::VOICE_W'(pick_q) : '0;
            out_gate_q   <= found_q && (op_q == vca_pkg::OP_NOTE_ON);
            out_note_q   <= note_q;
            out_vel_q    <= (found_q && (op_q == vca_pkg::OP_NOTE_ON)) ? vel_q : '0;
            out_stolen_q <= found_q && stolen_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
